// File: src/arpig_pkg.sv
`timescale 1ns / 1ps
// arpig_pkg: shared field widths, input kind codes, register indexes, reset values
// and the sequencer state type of the audio rate loop. No dependencies.
package arpig_pkg;

  localparam int KIND_W    = 2;
  localparam int QUEUE_W   = 16;
  localparam int IVL_W     = 16;
  localparam int RATE_W    = 25;
  localparam int ACC_W     = 26;
  localparam int CLK_W     = 27;
  localparam int CFG_W     = 27;
  localparam int CFG_IDX_W = 3;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [IVL_W-1:0]  IVL_MAX  = '1;

  // register reset values
  localparam logic [26:0] CLOCK_HZ_RST     = 27'd16777216;
  localparam logic [15:0] NOMINAL_RST      = 16'd48000;
  localparam logic [15:0] TARGET_Q_RST     = 16'd4096;
  localparam logic [15:0] QUEUE_LIMIT_RST  = 16'd16384;
  localparam logic [15:0] NUDGE_GAIN_RST   = 16'd3277;
  localparam logic [23:0] NUDGE_LIMIT_RST  = 24'd128000;
  localparam logic [16:0] SMOOTH_GAIN_RST  = 17'd3277;
  localparam logic [15:0] DEVIATION_RST    = 16'd1311;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ    = 3'd0,
    REG_NOMINAL     = 3'd1,
    REG_TARGET_Q    = 3'd2,
    REG_QUEUE_LIMIT = 3'd3,
    REG_NUDGE_GAIN  = 3'd4,
    REG_NUDGE_LIMIT = 3'd5,
    REG_SMOOTH_GAIN = 3'd6,
    REG_DEVIATION   = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_DEV,
    ST_F_ERR,
    ST_F_TGT,
    ST_F_DIFF,
    ST_F_SMUL,
    ST_F_SUM,
    ST_F_BAND,
    ST_F_SAT,
    ST_T_DIV,
    ST_T_ACC,
    ST_T_FIX,
    ST_DONE
  } state_t;

endpackage

// File: src/arpig_ifs.sv
`timescale 1ns / 1ps
// arpig_req_if / arpig_rsp_if: valid/ready channels carrying request and result words.
// Depends on arpig_pkg for field widths.
interface arpig_req_if;
  logic                          valid;
  logic                          ready;
  logic [arpig_pkg::KIND_W-1:0]  kind;
  logic [arpig_pkg::QUEUE_W-1:0] queued_samples;

  modport source (output valid, output kind, output queued_samples, input ready);
  modport sink   (input valid, input kind, input queued_samples, output ready);
endinterface

interface arpig_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [arpig_pkg::IVL_W-1:0]  interval_cycles;
  logic                         push_allowed;
  logic [arpig_pkg::RATE_W-1:0] rate_now_q8;

  modport source (output valid, output interval_cycles, output push_allowed,
                  output rate_now_q8, input ready);
  modport sink   (input valid, input interval_cycles, input push_allowed,
                  input rate_now_q8, output ready);
endinterface

// File: src/audio_rate_pll_interval_gen_top.sv
`timescale 1ns / 1ps
// audio_rate_pll_interval_gen_top: audio rate loop and sample interval generator.
// Depends on arpig_pkg and the channel interfaces in arpig_ifs.sv.

// The block holds an audio sample rate in units of 2^-FRAC_BITS Hz and takes one request
// word at a time. A frame update (kind 0) reports whether a push is allowed (queue below
// queue_limit), derives a nudge from the target queue level minus the queue level, smooths
// the rate toward nominal plus nudge and clamps it to the deviation band around nominal. A
// sample tick (kind 1) returns clock_hz * 2^FRAC_BITS / rate in clock cycles, carrying the
// remainder in a fractional accumulator so the mean interval is exact; intervals saturate
// at 65535. A restart (kind 2) clears the accumulator; kind 3 changes nothing. Every result
// word carries the rate after the request. A frame update runs eight steps through one
// shared 18-bit-by-wide signed multiplier and its adders; a sample tick runs a restoring
// divider retiring one quotient bit per cycle over 27 + FRAC_BITS bits; restart and
// unknown kinds go straight to the result. The result sits in an output register, so a
// new request is taken while the previous result waits.
// Configuration is a write port: cfg_we with cfg_idx selecting the register and cfg_wdata
// holding the value, LSB aligned; write only while the block is idle.
module audio_rate_pll_interval_gen_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  arpig_req_if.sink                          req,
  arpig_rsp_if.source                        rsp,
  input  logic                               cfg_we,
  input  logic [arpig_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [arpig_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int NW   = 16 + FRAC_BITS;                 // nominal rate width
  localparam int BW   = ((NW > 25) ? NW : 25) + 2;      // signed work width
  localparam int PW   = BW + 18;                        // product width
  localparam int RW   = BW + 2;                         // smoothed rate sum width
  localparam int NUMW = arpig_pkg::CLK_W + FRAC_BITS;   // dividend width
  localparam int CW   = $clog2(NUMW + 1);

  localparam longint unsigned NOM_RST_Q =
    64'(arpig_pkg::NOMINAL_RST) << FRAC_BITS;
  localparam logic [arpig_pkg::RATE_W-1:0] RATE_RST =
    (NOM_RST_Q > 64'(arpig_pkg::RATE_MAX)) ? arpig_pkg::RATE_MAX
                                           : NOM_RST_Q[arpig_pkg::RATE_W-1:0];

  // configuration registers
  logic [26:0] clock_hz;
  logic [15:0] nominal_rate_hz;
  logic [15:0] target_level;
  logic [15:0] queue_limit;
  logic [15:0] nudge_gain_q8;
  logic [23:0] nudge_limit_q8;
  logic [16:0] smooth_gain_q16;
  logic [15:0] deviation_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz        <= arpig_pkg::CLOCK_HZ_RST;
      nominal_rate_hz <= arpig_pkg::NOMINAL_RST;
      target_level    <= arpig_pkg::TARGET_Q_RST;
      queue_limit     <= arpig_pkg::QUEUE_LIMIT_RST;
      nudge_gain_q8   <= arpig_pkg::NUDGE_GAIN_RST;
      nudge_limit_q8  <= arpig_pkg::NUDGE_LIMIT_RST;
      smooth_gain_q16 <= arpig_pkg::SMOOTH_GAIN_RST;
      deviation_q16   <= arpig_pkg::DEVIATION_RST;
    end else if (cfg_we) begin
      unique case (arpig_pkg::cfg_reg_t'(cfg_idx))
        arpig_pkg::REG_CLOCK_HZ:    clock_hz        <= cfg_wdata[26:0];
        arpig_pkg::REG_NOMINAL:     nominal_rate_hz <= cfg_wdata[15:0];
        arpig_pkg::REG_TARGET_Q:    target_level    <= cfg_wdata[15:0];
        arpig_pkg::REG_QUEUE_LIMIT: queue_limit     <= cfg_wdata[15:0];
        arpig_pkg::REG_NUDGE_GAIN:  nudge_gain_q8   <= cfg_wdata[15:0];
        arpig_pkg::REG_NUDGE_LIMIT: nudge_limit_q8  <= cfg_wdata[23:0];
        arpig_pkg::REG_SMOOTH_GAIN: smooth_gain_q16 <= cfg_wdata[16:0];
        arpig_pkg::REG_DEVIATION:   deviation_q16   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // loop state and sequencer registers
  arpig_pkg::state_t state, state_next;

  logic [arpig_pkg::RATE_W-1:0]  rate_q8;
  logic [arpig_pkg::ACC_W-1:0]   frac_accum;
  logic [arpig_pkg::QUEUE_W-1:0] q_r;
  logic                          push_r;
  logic [arpig_pkg::IVL_W-1:0]   iv_res;
  logic [NW-1:0]                 dev_r;
  logic signed [BW-1:0]          wk;       // target rate, then its distance from rate
  logic signed [RW-1:0]          rs;       // smoothed rate, then its band clamp
  logic [NUMW-1:0]               quo;      // dividend shifting out, quotient shifting in
  logic [arpig_pkg::RATE_W-1:0]  rem;
  logic [CW-1:0]                 cnt;

  logic                          out_valid;
  logic [arpig_pkg::IVL_W-1:0]   out_ivl;
  logic                          out_push;
  logic [arpig_pkg::RATE_W-1:0]  out_rate;

  logic accept;
  logic out_load;

  // shared multiplier, product registered
  logic signed [BW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic signed [PW-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // combinational datapath terms
  logic [NW-1:0]           nom;
  logic signed [16:0]      err;
  logic signed [PW-9:0]    nudge;
  logic signed [PW-9:0]    lim_s;
  logic signed [PW-9:0]    nudge_c;
  logic [NW-1:0]           band_lo;
  logic [NW:0]             band_hi;
  logic signed [RW-1:0]    rate_ext;
  logic signed [RW-1:0]    lo_ext;
  logic signed [RW-1:0]    hi_ext;
  logic signed [RW-1:0]    max_ext;
  logic [arpig_pkg::ACC_W-1:0] trial;
  logic                    div_ge;
  logic [arpig_pkg::ACC_W-1:0] rate_acc;
  logic                    acc_ge;

  assign nom      = {nominal_rate_hz, {FRAC_BITS{1'b0}}};
  assign err      = $signed({1'b0, target_level}) - $signed({1'b0, q_r});
  assign nudge    = $signed(prod[PW-1:8]);        // floor of product / 256
  assign lim_s    = $signed((PW-8)'(nudge_limit_q8));
  assign band_lo  = nom - dev_r;
  assign band_hi  = {1'b0, nom} + {1'b0, dev_r};
  assign rate_ext = $signed(RW'(rate_q8));
  assign lo_ext   = $signed(RW'(band_lo));
  assign hi_ext   = $signed(RW'(band_hi));
  assign max_ext  = $signed(RW'(arpig_pkg::RATE_MAX));
  assign rate_acc = {1'b0, rate_q8};
  assign trial    = {rem, quo[NUMW-1]};
  assign div_ge   = trial >= rate_acc;
  assign acc_ge   = frac_accum >= rate_acc;

  always_comb begin
    if (nudge > lim_s) begin
      nudge_c = lim_s;
    end else if (nudge < -lim_s) begin
      nudge_c = -lim_s;
    end else begin
      nudge_c = nudge;
    end
  end

  assign accept   = req.valid && req.ready;
  assign out_load = (state == arpig_pkg::ST_DONE) && (!out_valid || rsp.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arpig_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    mul_a      = wk;
    mul_b      = $signed({1'b0, smooth_gain_q16});
    unique case (state)
      arpig_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.kind == arpig_pkg::KIND_FRAME) begin
            state_next = arpig_pkg::ST_F_DEV;
          end else if (req.kind == arpig_pkg::KIND_TICK && rate_q8 != '0) begin
            state_next = arpig_pkg::ST_T_DIV;
          end else begin
            state_next = arpig_pkg::ST_DONE;
          end
        end
      end
      arpig_pkg::ST_F_DEV: begin
        mul_a      = $signed(BW'(nom));
        mul_b      = $signed({2'b00, deviation_q16});
        state_next = arpig_pkg::ST_F_ERR;
      end
      arpig_pkg::ST_F_ERR: begin
        mul_a      = BW'(err);
        mul_b      = $signed({2'b00, nudge_gain_q8});
        state_next = arpig_pkg::ST_F_TGT;
      end
      arpig_pkg::ST_F_TGT:  state_next = arpig_pkg::ST_F_DIFF;
      arpig_pkg::ST_F_DIFF: state_next = arpig_pkg::ST_F_SMUL;
      arpig_pkg::ST_F_SMUL: state_next = arpig_pkg::ST_F_SUM;
      arpig_pkg::ST_F_SUM:  state_next = arpig_pkg::ST_F_BAND;
      arpig_pkg::ST_F_BAND: state_next = arpig_pkg::ST_F_SAT;
      arpig_pkg::ST_F_SAT:  state_next = arpig_pkg::ST_DONE;
      arpig_pkg::ST_T_DIV: begin
        if (cnt == CW'(NUMW - 1)) begin
          state_next = arpig_pkg::ST_T_ACC;
        end
      end
      arpig_pkg::ST_T_ACC: state_next = arpig_pkg::ST_T_FIX;
      arpig_pkg::ST_T_FIX: state_next = arpig_pkg::ST_DONE;
      arpig_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = arpig_pkg::ST_IDLE;
        end
      end
      default: state_next = arpig_pkg::ST_IDLE;
    endcase
  end

  // loop state: rate and fractional accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_q8    <= RATE_RST;
      frac_accum <= '0;
    end else begin
      if (accept && req.kind == arpig_pkg::KIND_RESTART) begin
        frac_accum <= '0;
      end
      if (state == arpig_pkg::ST_T_ACC) begin
        frac_accum <= frac_accum + {1'b0, rem};   // wraps at 26 bits
      end
      if (state == arpig_pkg::ST_T_FIX && acc_ge) begin
        frac_accum <= frac_accum - rate_acc;
      end
      if (state == arpig_pkg::ST_F_SAT) begin
        if (rs > max_ext) begin
          rate_q8 <= arpig_pkg::RATE_MAX;
        end else if (rs < 0) begin
          rate_q8 <= '0;
        end else begin
          rate_q8 <= rs[arpig_pkg::RATE_W-1:0];
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r    <= req.queued_samples;
      push_r <= (req.kind == arpig_pkg::KIND_FRAME) && (req.queued_samples < queue_limit);
      iv_res <= (req.kind == arpig_pkg::KIND_TICK) ? arpig_pkg::IVL_MAX : '0;
      quo    <= {clock_hz, {FRAC_BITS{1'b0}}};
      rem    <= '0;
      cnt    <= '0;
    end
    unique case (state)
      arpig_pkg::ST_F_ERR:  dev_r <= prod[NW+15:16];
      arpig_pkg::ST_F_TGT:  wk    <= BW'(nudge_c) + $signed(BW'(nom));
      arpig_pkg::ST_F_DIFF: wk    <= wk - $signed(BW'(rate_q8));
      arpig_pkg::ST_F_SUM:  rs    <= $signed(prod[PW-1:16]) + rate_ext;
      arpig_pkg::ST_F_BAND: begin
        if (rs < lo_ext) begin
          rs <= lo_ext;
        end else if (rs > hi_ext) begin
          rs <= hi_ext;
        end
      end
      arpig_pkg::ST_T_DIV: begin
        rem <= div_ge ? 25'(trial - rate_acc) : trial[arpig_pkg::RATE_W-1:0];
        quo <= {quo[NUMW-2:0], div_ge};
        cnt <= cnt + 1'b1;
      end
      arpig_pkg::ST_T_FIX: begin
        if (quo >= NUMW'(arpig_pkg::IVL_MAX)) begin
          iv_res <= arpig_pkg::IVL_MAX;
        end else begin
          iv_res <= quo[arpig_pkg::IVL_W-1:0] + arpig_pkg::IVL_W'(acc_ge);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ivl  <= iv_res;
      out_push <= push_r;
      out_rate <= rate_q8;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.interval_cycles = out_ivl;
  assign rsp.push_allowed    = out_push;
  assign rsp.rate_now_q8     = out_rate;

endmodule
